[rtl/core/skt_pkg.sv]
// ============================================================================
// skt_pkg - shared types and codes for the sorted key table
// Word layouts for both channels, op and status codes, cell command types.
// ============================================================================
`default_nettype none

package skt_pkg;

    localparam int unsigned CAPACITY_DEF     = 16;
    localparam int unsigned PAYLOAD_BITS_DEF = 32;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned KEY_W      = 16;
    localparam int unsigned SKEY_W     = 15;   // stored keys are never negative
    localparam int unsigned PAY_W      = 32;
    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned COUNT_W    = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEG      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic signed [KEY_W-1:0] KEY_NONE = -16'sd1;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key_in;
        logic [PAY_W-1:0]        payload_in;
        logic [INDEX_W-1:0]      index_in;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] key_out;
        logic [PAY_W-1:0]        payload_out;
        logic [COUNT_W-1:0]      entry_count;
    } out_word_t;

    // Broadcast to every cell. sample: latch compare flags; do_*: update.
    typedef struct packed {
        logic                sample;
        logic [OP_W-1:0]     op;
        logic                key_neg;
        logic [SKEY_W-1:0]   key;
        logic [PAY_W-1:0]    payload;
        logic [INDEX_W-1:0]  index;
        logic                do_insert;
        logic                do_remove;
        logic                do_clear;
    } cell_cmd_t;

    typedef struct packed {
        logic lt;    // valid and stored key below search key
        logic eq;    // valid and stored key equal to search key
        logic sel;   // this cell supplies the find or read result
    } cell_flag_t;

endpackage : skt_pkg

`default_nettype wire

[rtl/core/skt_cell.sv]
// ============================================================================
// skt_cell - one slot of the sorted table
// Holds valid, key and payload; compares against the broadcast key and
// shifts toward or away from its neighbors on insert and remove.
// ============================================================================
`default_nettype none

module skt_cell
    import skt_pkg::*;
#(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned STORE_BITS = PAY_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cell_cmd_t             cmd,
    // left neighbor (lower position); cell 0 sees a tied-off phantom
    input  wire logic                  left_valid,
    input  wire logic                  left_lt,
    input  wire logic [SKEY_W-1:0]     left_key,
    input  wire logic [STORE_BITS-1:0] left_payload,
    // right neighbor (higher position); last cell sees an empty slot
    input  wire logic                  right_valid,
    input  wire logic [SKEY_W-1:0]     right_key,
    input  wire logic [STORE_BITS-1:0] right_payload,
    output logic                       valid,
    output logic [SKEY_W-1:0]          key,
    output logic [STORE_BITS-1:0]      payload,
    output cell_flag_t                 flag,
    output logic [SKEY_W-1:0]          hit_key,
    output logic [STORE_BITS-1:0]      hit_payload
);

    logic                  valid_reg, valid_next;
    logic [SKEY_W-1:0]     key_reg, key_next;
    logic [STORE_BITS-1:0] payload_reg, payload_next;
    cell_flag_t            flag_reg, flag_next;

    always_comb begin
        flag_next.lt  = valid_reg && !cmd.key_neg && (key_reg < cmd.key);
        flag_next.eq  = valid_reg && !cmd.key_neg && (key_reg == cmd.key);
        case (cmd.op)
            OP_FIND: flag_next.sel = flag_next.eq;
            OP_READ: flag_next.sel = valid_reg && (cmd.index == INDEX_W'(INDEX));
            default: flag_next.sel = 1'b0;
        endcase
    end

    // Sorted packing keeps lt a prefix, so !lt marks the slot at or past
    // the insert/remove point.
    always_comb begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.do_clear) begin
            valid_next = 1'b0;
        end else if (cmd.do_insert) begin
            valid_next = valid_reg | left_valid;
            if (!flag_reg.lt) begin
                if (left_lt) begin
                    key_next     = cmd.key;
                    payload_next = cmd.payload[STORE_BITS-1:0];
                end else begin
                    key_next     = left_key;
                    payload_next = left_payload;
                end
            end
        end else if (cmd.do_remove) begin
            if (!flag_reg.lt) begin
                valid_next   = right_valid;
                key_next     = right_key;
                payload_next = right_payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            flag_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.sample) begin
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign valid       = valid_reg;
    assign key         = key_reg;
    assign payload     = payload_reg;
    assign flag        = flag_reg;
    assign hit_key     = flag_reg.sel ? key_reg : '0;
    assign hit_payload = flag_reg.sel ? payload_reg : '0;

endmodule : skt_cell

`default_nettype wire

[rtl/core/sorted_key_table_unit.sv]
// ============================================================================
// sorted_key_table_unit - sorted key/payload table built as a cell chain
// Keeps valid entries packed in ascending key order; insert, remove, find,
// read by position and clear, each answered by one result word.
// ============================================================================
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_valid / s_ready  | in_word_t  (op, key, payload, index)
//  m_      | out | m_valid / m_ready  | out_word_t (status, key, payload, count)
//
//  Each word passes through S_IDLE and S_EXEC. The accept edge latches
//  compare flags in every cell (all cells compare the key in parallel);
//  the commit in S_EXEC resolves status, shifts the chain one slot and
//  loads the output register. A held output register stalls that commit;
//  s_ready stays low until it is done, and then the next word can be taken.
//  Reset empties the table (valid bits only).
//
`default_nettype none

module sorted_key_table_unit
    import skt_pkg::*;
#(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam int unsigned STORE_BITS = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg;
    logic               key_neg_reg;
    logic [SKEY_W-1:0]  key_reg;
    logic [PAY_W-1:0]   payload_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    cell_cmd_t          cmd;

    // per-cell taps
    logic                  c_valid   [CAPACITY];
    logic [SKEY_W-1:0]     c_key     [CAPACITY];
    logic [STORE_BITS-1:0] c_payload [CAPACITY];
    cell_flag_t            c_flag    [CAPACITY];
    logic [SKEY_W-1:0]     c_hkey    [CAPACITY];
    logic [STORE_BITS-1:0] c_hpay    [CAPACITY];

    logic                  found;
    logic                  any_sel;
    logic [SKEY_W-1:0]     sel_key;
    logic [STORE_BITS-1:0] sel_payload;

    logic                  do_insert, do_remove, do_clear;
    logic [STATUS_W-1:0]   status;
    logic signed [KEY_W-1:0] key_out;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    // Compare on the accept edge uses the live input; the update step uses
    // the held copy.
    always_comb begin
        cmd.sample    = accept;
        cmd.op        = s_data.op;
        cmd.key_neg   = s_data.key_in[KEY_W-1];
        cmd.key       = s_ready ? s_data.key_in[SKEY_W-1:0] : key_reg;
        cmd.payload   = payload_reg;
        cmd.index     = s_data.index_in;
        cmd.do_insert = do_insert;
        cmd.do_remove = do_remove;
        cmd.do_clear  = do_clear;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                  l_valid, l_lt, r_valid;
        logic [SKEY_W-1:0]     l_key, r_key;
        logic [STORE_BITS-1:0] l_pay, r_pay;

        if (g == 0) begin : g_first
            assign l_valid = 1'b1;
            assign l_lt    = 1'b1;
            assign l_key   = '0;
            assign l_pay   = '0;
        end else begin : g_mid
            assign l_valid = c_valid[g-1];
            assign l_lt    = c_flag[g-1].lt;
            assign l_key   = c_key[g-1];
            assign l_pay   = c_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_pay   = '0;
        end else begin : g_inner
            assign r_valid = c_valid[g+1];
            assign r_key   = c_key[g+1];
            assign r_pay   = c_payload[g+1];
        end

        skt_cell #(
            .INDEX      (g),
            .STORE_BITS (STORE_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .left_valid    (l_valid),
            .left_lt       (l_lt),
            .left_key      (l_key),
            .left_payload  (l_pay),
            .right_valid   (r_valid),
            .right_key     (r_key),
            .right_payload (r_pay),
            .valid         (c_valid[g]),
            .key           (c_key[g]),
            .payload       (c_payload[g]),
            .flag          (c_flag[g]),
            .hit_key       (c_hkey[g]),
            .hit_payload   (c_hpay[g])
        );
    end

    // At most one cell selects, so a plain OR picks its entry.
    always_comb begin
        found       = 1'b0;
        any_sel     = 1'b0;
        sel_key     = '0;
        sel_payload = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found       = found | c_flag[i].eq;
            any_sel     = any_sel | c_flag[i].sel;
            sel_key     = sel_key | c_hkey[i];
            sel_payload = sel_payload | c_hpay[i];
        end
    end

    // Status resolution; insert checks go negative, duplicate, full.
    always_comb begin
        status     = ST_OK;
        key_out    = KEY_NONE;
        count_next = count_reg;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        do_clear   = 1'b0;
        case (op_reg)
            OP_INSERT: begin
                if (key_neg_reg) begin
                    status = ST_NEG;
                end else if (found) begin
                    status = ST_DUP;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    do_insert  = commit;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    status = ST_NOTFOUND;
                end else begin
                    do_remove  = commit;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_FIND, OP_READ: begin
                if (!any_sel) begin
                    status = ST_NOTFOUND;
                end else begin
                    key_out = KEY_W'({1'b0, sel_key});
                end
            end
            OP_CLEAR: begin
                do_clear   = commit;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= s_data.op;
            key_neg_reg <= s_data.key_in[KEY_W-1];
            key_reg     <= s_data.key_in[SKEY_W-1:0];
            payload_reg <= s_data.payload_in;
        end
        if (commit) begin
            m_data_reg.status      <= status;
            m_data_reg.key_out     <= key_out;
            m_data_reg.payload_out <= PAY_W'(sel_payload);
            m_data_reg.entry_count <= COUNT_W'(count_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule : sorted_key_table_unit

`default_nettype wire

[rtl/core/skt_checker.sv]
// ============================================================================
// skt_checker - port-level checks for the sorted key table
// Watches both channels of the top level; attached by bind.
// ============================================================================
`default_nettype none

module skt_checker
    import skt_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_word_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_word_t m_data
);

    // input word holds while waiting
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // result word holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // after each accepted word s_ready drops before the next can be taken
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

    // not found never carries entry data
    a_nf_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_NOTFOUND) |->
            (m_data.key_out == KEY_NONE) && (m_data.payload_out == '0))
        else $error("not-found result carries entry data");

endmodule : skt_checker

bind sorted_key_table_unit skt_checker u_skt_checker (.*);

`default_nettype wire

[tb/sorted_key_table_unit_tb.sv]
// ============================================================================
// sorted_key_table_unit_tb - self-checking bench for the sorted key table
// Drives insert/remove/find/read/clear words with random idle on both
// channels. Every accepted word runs through a local table model, and each
// result word is checked field by field against the oldest prediction.
// ============================================================================

module sorted_key_table_unit_tb;
    import skt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycle limit for the watchdog below.
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned TABLE_CAP    = CAPACITY_DEF;
    localparam int unsigned POOL_SIZE    = 24;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Local table model: packed front entries in ascending key order.
    logic [SKEY_W-1:0] tbl_key [TABLE_CAP];
    logic [PAY_W-1:0]  tbl_pay [TABLE_CAP];
    int unsigned       tbl_count;

    out_word_t         expected_words[$];
    logic [SKEY_W-1:0] key_pool [POOL_SIZE];
    int unsigned       mismatches;
    int unsigned       words_checked;
    int unsigned       cycle_count;
    logic              steady;   // 1: neither side idles

    sorted_key_table_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: m_ready changes on the falling edge, low ~15% of cycles unless steady.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = steady || ($urandom_range(99) >= 15);
        end
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------

    // Slot holding key k, or tbl_count when absent.
    function automatic int unsigned key_slot(input logic [SKEY_W-1:0] k);
        int unsigned i;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) return i;
        end
        return tbl_count;
    endfunction

    // Applies one accepted word to the model and returns the result word.
    function automatic out_word_t apply_table_op(input in_word_t w);
        out_word_t         r;
        logic [SKEY_W-1:0] k;
        logic              neg;
        int unsigned       hit;
        int unsigned       slot;
        int unsigned       i;
        k             = w.key_in[SKEY_W-1:0];
        neg           = w.key_in[KEY_W-1];
        r.status      = ST_OK;
        r.key_out     = KEY_NONE;
        r.payload_out = '0;
        // negative keys are never stored, so never matched
        hit = neg ? tbl_count : key_slot(k);
        case (w.op)
            OP_INSERT: begin
                // check order matters: negative, then duplicate, then full
                if (neg) begin
                    r.status = ST_NEG;
                end else if (hit < tbl_count) begin
                    r.status = ST_DUP;
                end else if (tbl_count >= TABLE_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < tbl_count && tbl_key[slot] < k) slot++;
                    for (i = tbl_count; i > slot; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_pay[i] = tbl_pay[i-1];
                    end
                    tbl_key[slot] = k;
                    tbl_pay[slot] = w.payload_in;
                    tbl_count++;
                end
            end
            OP_REMOVE: begin
                if (hit >= tbl_count) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    // close the gap
                    for (i = hit; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_pay[i] = tbl_pay[i+1];
                    end
                    tbl_count--;
                end
            end
            OP_FIND: begin
                if (hit >= tbl_count) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.key_out     = {1'b0, tbl_key[hit]};
                    r.payload_out = tbl_pay[hit];
                end
            end
            OP_READ: begin
                if (w.index_in >= tbl_count) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.key_out     = {1'b0, tbl_key[w.index_in]};
                    r.payload_out = tbl_pay[w.index_in];
                end
            end
            OP_CLEAR: begin
                tbl_count = 0;
            end
            default: begin
                // unknown op: table untouched, plain ok word
            end
        endcase
        r.entry_count = COUNT_W'(tbl_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s of word %0d: expected %0h, got %0h",
                         name, words_checked, exp_v, got_v);
        end
    endtask

    // Result words are taken at the rising edge, values as seen before it.
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %0h", m_data);
            end else begin
                exp_w = expected_words.pop_front();
                check_field("status",      32'(exp_w.status),      32'(m_data.status));
                check_field("key_out",     32'(exp_w.key_out[KEY_W-1:0]),
                            32'(m_data.key_out[KEY_W-1:0]));
                check_field("payload_out", 32'(exp_w.payload_out), 32'(m_data.payload_out));
                check_field("entry_count", 32'(exp_w.entry_count), 32'(m_data.entry_count));
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Sends one word; valid stays high from word to word unless a gap is
    // drawn. The model runs at the accepting edge.
    task automatic send_op(input logic [OP_W-1:0] op,
                           input logic signed [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay,
                           input logic [INDEX_W-1:0] idx);
        in_word_t w;
        int       gap;
        w.op         = op;
        w.key_in     = key;
        w.payload_in = pay;
        w.index_in   = idx;
        gap = 0;
        if (!steady && $urandom_range(99) < 15) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(apply_table_op(w));
    endtask

    // Drops valid and holds off until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Field generators
    // ------------------------------------------------------------------------

    // Mostly keys from a small pool or the table, so hits and dups are common.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return {1'b0, key_pool[$urandom_range(POOL_SIZE - 1)]};
        if (r < 75 && tbl_count > 0)
            return {1'b0, tbl_key[$urandom_range(tbl_count - 1)]};
        if (r < 90)
            return KEY_W'($urandom);
        return {1'b1, SKEY_W'($urandom)};
    endfunction

    // Non-negative key not in the table right now.
    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic [SKEY_W-1:0] k;
        k = SKEY_W'($urandom);
        while (key_slot(k) < tbl_count) k = SKEY_W'($urandom);
        return {1'b0, k};
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(99) < 70) return INDEX_W'($urandom_range(TABLE_CAP + 1));
        return INDEX_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge values, every op, rejects, misses and unknown codes.
    task automatic test_directed();
        send_op(OP_READ,   16'sd0,      32'h0,        8'd0);    // read on empty
        send_op(OP_FIND,   16'sd5,      32'h0,        8'd0);    // find on empty
        send_op(OP_REMOVE, 16'sd5,      32'h0,        8'd0);    // remove on empty
        send_op(OP_INSERT, 16'sd0,      32'h0,        8'd0);
        send_op(OP_INSERT, 16'sd32767,  32'hFFFF_FFFF, 8'hFF);
        send_op(OP_INSERT, 16'sd100,    32'hA5A5_A5A5, 8'd0);   // lands in middle
        send_op(OP_INSERT, -16'sd32768, 32'h1234_5678, 8'd0);   // negative key
        send_op(OP_INSERT, -16'sd1,     32'h0,        8'd0);    // negative key
        send_op(OP_INSERT, 16'sd100,    32'h5A5A_5A5A, 8'd0);   // duplicate
        send_op(OP_FIND,   16'sd0,      32'h0,        8'd0);
        send_op(OP_FIND,   16'sd32767,  32'h0,        8'd0);
        send_op(OP_FIND,   -16'sd1,     32'h0,        8'd0);    // negative never hits
        send_op(OP_FIND,   16'sd101,    32'h0,        8'd0);    // absent
        send_op(OP_READ,   16'sd0,      32'h0,        8'd0);
        send_op(OP_READ,   16'sd0,      32'h0,        8'd1);
        send_op(OP_READ,   16'sd0,      32'h0,        8'd2);
        send_op(OP_READ,   16'sd0,      32'h0,        8'd3);    // past the entries
        send_op(OP_READ,   -16'sd1,     32'hFFFF_FFFF, 8'd255); // far past capacity
        send_op(OP_REMOVE, 16'sd100,    32'h0,        8'd0);    // middle, gap closes
        send_op(OP_REMOVE, 16'sd100,    32'h0,        8'd0);    // now absent
        send_op(OP_REMOVE, -16'sd32768, 32'h0,        8'd0);    // negative remove
        send_op(3'd5,      16'sd0,      32'hFFFF_FFFF, 8'd1);   // unknown ops
        send_op(3'd6,      -16'sd1,     32'h0,        8'd0);
        send_op(3'd7,      16'sd32767,  32'h8000_0001, 8'hFF);
        send_op(OP_CLEAR,  16'sd0,      32'h0,        8'd0);
        send_op(OP_READ,   16'sd0,      32'h0,        8'd0);    // empty after clear
    endtask

    // Fill to capacity, hit the full reject, read every slot, pause until
    // drained, then empty the table again by removes in random order.
    task automatic test_fill_and_drain();
        int unsigned i;
        send_op(OP_CLEAR, 16'sd0, 32'h0, 8'd0);
        while (tbl_count < TABLE_CAP) begin
            if ($urandom_range(9) == 0)
                send_op(OP_INSERT, pick_key(), pick_payload(), pick_index());
            else
                send_op(OP_INSERT, fresh_key(), pick_payload(), pick_index());
        end
        send_op(OP_INSERT, fresh_key(), pick_payload(), 8'd0);               // full
        send_op(OP_INSERT, {1'b1, SKEY_W'($urandom)}, pick_payload(), 8'd0); // neg wins
        send_op(OP_INSERT, {1'b0, tbl_key[$urandom_range(TABLE_CAP - 1)]},
                pick_payload(), 8'd0);                                       // dup wins
        for (i = 0; i <= TABLE_CAP; i++)
            send_op(OP_READ, pick_key(), pick_payload(), INDEX_W'(i));
        wait_drained();
        while (tbl_count > 0) begin
            if ($urandom_range(7) == 0)
                send_op(OP_REMOVE, fresh_key(), pick_payload(), pick_index());
            else
                send_op(OP_REMOVE, {1'b0, tbl_key[$urandom_range(tbl_count - 1)]},
                        pick_payload(), pick_index());
        end
    endtask

    // Weighted mix of all ops with pool-heavy keys.
    task automatic test_random_mix(input int unsigned n_words);
        int unsigned       n;
        int unsigned       r;
        logic [OP_W-1:0]   op;
        for (n = 0; n < n_words; n++) begin
            r = $urandom_range(99);
            if (r < 35)      op = OP_INSERT;
            else if (r < 55) op = OP_REMOVE;
            else if (r < 72) op = OP_FIND;
            else if (r < 88) op = OP_READ;
            else if (r < 91) op = OP_CLEAR;
            else if (r < 94) op = OP_W'($urandom_range(5, 7));
            else             op = OP_INSERT;
            send_op(op, pick_key(), pick_payload(), pick_index());
        end
    endtask

    // Same mix with both sides running flat out.
    task automatic test_back_to_back();
        steady = 1'b1;
        test_random_mix(150);
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        int unsigned i;
        s_valid       = 1'b0;
        s_data        = '0;
        aresetn       = 1'b0;
        steady        = 1'b0;
        tbl_count     = 0;
        mismatches    = 0;
        words_checked = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++) key_pool[i] = SKEY_W'($urandom);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_mix(350);
        test_back_to_back();
        test_fill_and_drain();
        test_random_mix(350);
        test_fill_and_drain();

        // let everything retire, then watch for stray words a while longer
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
